@@ rtl/assert_macros.svh @@
// Assertion macros shared by the deframer RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/bscd_pkg.sv @@
// Shared types, constants and CRC function for the byte stuffed deframer.
// No dependencies; imported by the deframer and the testbench.
`timescale 1ns / 1ps

package bscd_pkg;

  localparam int FRAME_LEN = 10;
  localparam int FCS_BYTES = 2;
  localparam int PAY_LEN   = FRAME_LEN - FCS_BYTES;
  localparam int ADDR_W    = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);
  localparam int INDEX_W   = 6;

  localparam logic [7:0]  FLAG_OPEN  = 8'hC0;
  localparam logic [7:0]  FLAG_CLOSE = 8'hC1;
  localparam logic [7:0]  ESC_BYTE   = 8'h7D;
  localparam logic [7:0]  ESC_XOR    = 8'h20;
  localparam logic [15:0] CRC_START  = 16'hFFFF;
  localparam logic [15:0] CRC_GOOD   = 16'h0000;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  typedef enum logic [1:0] {
    RX_OUTSIDE = 2'd0,
    RX_BEGIN   = 2'd1,
    RX_ESCAPE  = 2'd2,
    RX_INSIDE  = 2'd3
  } rx_state_t;

  typedef enum logic [2:0] {
    STAT_NONE     = 3'd0,
    STAT_GOOD     = 3'd1,
    STAT_LENGTH   = 3'd2,
    STAT_CRC      = 3'd3,
    STAT_MISSED   = 3'd4,
    STAT_OVERFLOW = 3'd5
  } status_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

@@ rtl/bscd_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module bscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/byte_stuffed_crc16_deframer.sv @@
// A result transfer is registered and offered in the cycle after its input transfer.
// Input takes one byte per cycle while the output is not stalled and no drain
// is running; a good closing flag yields PAY_LEN result transfers, read from the
// frame RAM one entry per cycle while the output is not stalled, and input is
// held off until the remaining PAY_LEN - 1 of them are taken.
// Reset (rst, synchronous): outside frame, count 0, CRC 0xFFFF, output empty;
// the frame RAM is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_stuffed_crc16_deframer
  import bscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] status, [10:3] payload_byte, [16:11] byte_index
  output logic        m_tlast    // last
);

  localparam logic [ADDR_W-1:0] PAY_LAST = ADDR_W'(PAY_LEN - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(FRAME_LEN);

  rx_state_t         rx_state, rx_state_next;
  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [15:0]       crc_accum, crc_accum_next;
  status_t           status_next;
  logic              good_close;
  logic              wr_en;
  logic [7:0]        wr_byte;

  logic              draining;
  logic [ADDR_W-1:0] drain_idx;

  logic              out_valid;
  status_t           out_status;
  logic              out_payload;
  logic [ADDR_W-1:0] out_index;
  logic              out_last;

  logic              advance;
  logic              accept;
  logic              drain_step;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign advance    = !out_valid || m_tready;
  assign s_tready   = advance && !draining;
  assign accept     = s_tvalid && s_tready;
  assign drain_step = draining && advance;
  assign rd_en      = (accept && good_close) || drain_step;
  assign rd_addr    = draining ? drain_idx : '0;

  always_comb begin
    rx_state_next   = rx_state;
    byte_count_next = byte_count;
    crc_accum_next  = crc_accum;
    status_next     = STAT_NONE;
    good_close      = 1'b0;
    wr_en           = 1'b0;
    wr_byte         = (rx_state == RX_ESCAPE) ? (s_tdata ^ ESC_XOR) : s_tdata;
    priority if (s_tdata == FLAG_OPEN) begin
      if (rx_state == RX_ESCAPE || rx_state == RX_INSIDE) begin
        status_next = STAT_MISSED;
      end
      rx_state_next   = RX_BEGIN;
      byte_count_next = '0;
      crc_accum_next  = CRC_START;
    end else if (s_tdata == FLAG_CLOSE) begin
      if (rx_state == RX_OUTSIDE) begin
        status_next = STAT_MISSED;
      end else begin
        rx_state_next = RX_OUTSIDE;
        priority if (byte_count != CNT_FULL) begin
          status_next = STAT_LENGTH;
        end else if (crc_accum != CRC_GOOD) begin
          status_next = STAT_CRC;
        end else begin
          status_next = STAT_GOOD;
          good_close  = 1'b1;
        end
      end
    end else if (s_tdata == ESC_BYTE) begin
      if (rx_state == RX_BEGIN || rx_state == RX_INSIDE) begin
        rx_state_next = RX_ESCAPE;
      end
    end else begin
      if (rx_state != RX_OUTSIDE) begin
        if (byte_count < CNT_FULL) begin
          rx_state_next   = RX_INSIDE;
          wr_en           = 1'b1;
          byte_count_next = byte_count + 1'b1;
          crc_accum_next  = crc_update(crc_accum, wr_byte);
        end else begin
          status_next   = STAT_OVERFLOW;
          rx_state_next = RX_OUTSIDE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_state   <= RX_OUTSIDE;
      byte_count <= '0;
      crc_accum  <= CRC_START;
    end else if (accept) begin
      rx_state   <= rx_state_next;
      byte_count <= byte_count_next;
      crc_accum  <= crc_accum_next;
    end
  end

  // Output stage and payload drain sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      draining  <= 1'b0;
      drain_idx <= '0;
    end else if (drain_step) begin
      out_valid <= 1'b1;
      drain_idx <= drain_idx + 1'b1;
      if (drain_idx == PAY_LAST) begin
        draining <= 1'b0;
      end
    end else if (accept) begin
      out_valid <= 1'b1;
      if (good_close && PAY_LEN > 1) begin
        draining  <= 1'b1;
        drain_idx <= ADDR_W'(1);
      end
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      out_status  <= STAT_GOOD;
      out_payload <= 1'b1;
      out_index   <= drain_idx;
      out_last    <= (drain_idx == PAY_LAST);
    end else if (accept) begin
      out_status  <= status_next;
      out_payload <= good_close;
      out_index   <= '0;
      out_last    <= !good_close || (PAY_LEN == 1);
    end
  end

  bscd_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (byte_count[ADDR_W-1:0]),
    .wr_data (wr_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'b0,
                     out_payload ? INDEX_W'(out_index) : INDEX_W'(0),
                     out_payload ? rd_data : 8'h00,
                     out_status};

  `ASSERT_NEVER(a_count_range, clk, rst, byte_count > CNT_FULL,
                "byte count beyond frame length")
  `ASSERT_NEVER(a_drain_outside, clk, rst, draining && rx_state != RX_OUTSIDE,
                "drain while in frame")
  `ASSERT_PROP(a_drain_end, clk, rst,
               $fell(draining) |-> (out_valid && out_last && out_status == STAT_GOOD),
               "drain ended without final payload")
  `ASSERT_PROP(a_payload_run, clk, rst,
               (out_valid && out_status == STAT_GOOD && !out_last) |-> draining,
               "payload run broken")

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for byte_stuffed_crc16_deframer: streams stuffed line bytes in,
// predicts status and payload transfers in its own deframer model and checks each one.
// Depends on bscd_pkg for frame constants, rx states and status codes.
`timescale 1ns / 1ps

module testbench;
  import bscd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LINE_BYTES  = 344;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data;
    logic [5:0]  index;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;   // [2:0] status, [10:3] payload_byte, [16:11] byte_index
  logic        m_tlast;   // last

  logic [7:0] pending_bytes[$];
  logic [7:0] frame_body[$];
  result_t    expected_results[$];

  rx_state_t  rx_st = RX_OUTSIDE;
  int         stored = 0;
  logic [15:0] crc_acc = CRC_START;
  logic [7:0] store [FRAME_LEN];

  int  errors = 0;
  int  n_in = 0;
  int  n_out = 0;
  int  n_good = 0;
  int  n_flagged = 0;
  int  cycles = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  steady = 1'b0;
  bit  hold_off = 1'b0;

  byte_stuffed_crc16_deframer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", n_out, what, got, want);
    errors++;
  endtask

  // Advance the deframer model by one line byte and queue the transfers it causes.
  task automatic deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    status_t    st;
    b = raw;
    st = STAT_NONE;
    if (b == FLAG_OPEN) begin
      if (rx_st == RX_ESCAPE || rx_st == RX_INSIDE) begin
        st = STAT_MISSED;
      end
      rx_st = RX_BEGIN;
      stored = 0;
      crc_acc = CRC_START;
    end else if (b == FLAG_CLOSE) begin
      if (rx_st == RX_OUTSIDE) begin
        st = STAT_MISSED;
      end else begin
        rx_st = RX_OUTSIDE;
        if (stored != FRAME_LEN) begin
          st = STAT_LENGTH;
        end else if (crc_acc != CRC_GOOD) begin
          st = STAT_CRC;
        end else begin
          for (int i = 0; i < PAY_LEN; i++) begin
            expected_results.push_back('{STAT_GOOD, store[i], 6'(i), i == PAY_LEN - 1});
          end
          n_good++;
          return;
        end
      end
    end else if (b == ESC_BYTE) begin
      if (rx_st == RX_BEGIN || rx_st == RX_INSIDE) begin
        rx_st = RX_ESCAPE;
      end
    end else if (rx_st != RX_OUTSIDE) begin
      if (rx_st == RX_ESCAPE) begin
        b = b ^ ESC_XOR;
      end
      if (stored < FRAME_LEN) begin
        rx_st = RX_INSIDE;
        store[stored] = b;
        stored++;
        crc_acc = crc_next(crc_acc, b);
      end else begin
        st = STAT_OVERFLOW;
        rx_st = RX_OUTSIDE;
      end
    end
    if (st != STAT_NONE) begin
      n_flagged++;
    end
    expected_results.push_back('{st, 8'h00, 6'd0, 1'b1});
  endtask

  // Escape flag and escape bytes always, other bytes now and then.
  task automatic push_stuffed(input logic [7:0] b);
    bit must, may;
    must = (b == FLAG_OPEN || b == FLAG_CLOSE || b == ESC_BYTE);
    may = !((b ^ ESC_XOR) == FLAG_OPEN || (b ^ ESC_XOR) == FLAG_CLOSE ||
            (b ^ ESC_XOR) == ESC_BYTE) && ($urandom_range(0, 15) == 0);
    if (must || may) begin
      pending_bytes.push_back(ESC_BYTE);
      pending_bytes.push_back(b ^ ESC_XOR);
    end else begin
      pending_bytes.push_back(b);
    end
  endtask

  task automatic push_body(input int n);
    pending_bytes.push_back(FLAG_OPEN);
    for (int i = 0; i < n && i < frame_body.size(); i++) begin
      push_stuffed(frame_body[i]);
    end
  endtask

  // Fill frame_body with random payload and its trailing CRC, low byte first.
  task automatic make_good_body();
    logic [15:0] c;
    frame_body.delete();
    c = CRC_START;
    for (int i = 0; i < PAY_LEN; i++) begin
      frame_body.push_back(8'($urandom_range(0, 255)));
      c = crc_next(c, frame_body[i]);
    end
    frame_body.push_back(c[7:0]);
    frame_body.push_back(c[15:8]);
  endtask

  task automatic close_good_payload(input logic [7:0] p [PAY_LEN]);
    logic [15:0] c;
    frame_body.delete();
    c = CRC_START;
    for (int i = 0; i < PAY_LEN; i++) begin
      frame_body.push_back(p[i]);
      c = crc_next(c, p[i]);
    end
    frame_body.push_back(c[7:0]);
    frame_body.push_back(c[15:8]);
    push_body(FRAME_LEN);
    pending_bytes.push_back(FLAG_CLOSE);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_gap <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        s_tdata <= pending_bytes.pop_front();
        s_tvalid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_stall <= 0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        out_stall <= pick_gap();
      end
    end
  end

  // Check results first; a byte accepted on this edge cannot have a result yet.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", m_tdata[2:0], 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[2:0] != want.status) begin
          report_mismatch("status", m_tdata[2:0], want.status);
        end
        if (m_tdata[10:3] != want.data) begin
          report_mismatch("payload_byte", m_tdata[10:3], want.data);
        end
        if (m_tdata[16:11] != want.index) begin
          report_mismatch("byte_index", m_tdata[16:11], want.index);
        end
        if (m_tlast != want.last) begin
          report_mismatch("last", m_tlast, want.last);
        end
      end
      n_out++;
    end
    if (!rst && s_tvalid && s_tready) begin
      deframe_byte(s_tdata);
      n_in++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    steady <= (cycles % 600) >= 500;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Hold the receiver off for a long stretch so the block backs up into its input.
  initial begin
    wait (n_in >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    logic [7:0] p [PAY_LEN];
    int kind, n;

    // Escapes in every state and flags in several, then a good frame full of special bytes.
    pending_bytes.push_back(FLAG_CLOSE);
    pending_bytes.push_back(ESC_BYTE);
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(FLAG_OPEN);
    pending_bytes.push_back(ESC_BYTE);
    pending_bytes.push_back(ESC_BYTE);
    pending_bytes.push_back(FLAG_OPEN);
    pending_bytes.push_back(8'hFF);
    pending_bytes.push_back(FLAG_CLOSE);
    pending_bytes.push_back(FLAG_OPEN);
    pending_bytes.push_back(8'h12);
    pending_bytes.push_back(ESC_BYTE);
    pending_bytes.push_back(FLAG_CLOSE);
    p = '{8'h00, 8'hFF, FLAG_OPEN, FLAG_CLOSE, ESC_BYTE, 8'h5D, 8'h80, 8'h01};
    close_good_payload(p);

    while (pending_bytes.size() < LINE_BYTES) begin
      kind = $urandom_range(0, 99);
      make_good_body();
      if (kind < 55) begin
        push_body(FRAME_LEN);
        pending_bytes.push_back(FLAG_CLOSE);
      end else if (kind < 65) begin
        n = $urandom_range(0, FRAME_LEN - 1);
        frame_body[n] = frame_body[n] ^ (8'h01 << $urandom_range(0, 7));
        push_body(FRAME_LEN);
        pending_bytes.push_back(FLAG_CLOSE);
      end else if (kind < 73) begin
        n = $urandom_range(0, FRAME_LEN - 1);
        push_body(n);
        pending_bytes.push_back(FLAG_CLOSE);
      end else if (kind < 80) begin
        push_body(FRAME_LEN);
        repeat ($urandom_range(1, 3)) push_stuffed(8'($urandom_range(0, 255)));
        pending_bytes.push_back(FLAG_CLOSE);
      end else if (kind < 86) begin
        push_body($urandom_range(0, FRAME_LEN));
        pending_bytes.push_back(ESC_BYTE);
        pending_bytes.push_back($urandom_range(0, 1) ? FLAG_OPEN : FLAG_CLOSE);
      end else if (kind < 90) begin
        push_body($urandom_range(1, FRAME_LEN));
      end else begin
        repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() > 0 || s_tvalid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch("results left over", expected_results.size(), 0);
    end

    $display("%0d line bytes in, %0d result transfers checked", n_in, n_out);
    $display("%0d good frames delivered, %0d error statuses reported", n_good, n_flagged);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
